// ===== design/alide_pkg.sv =====
// ---------------------------------------------------------------------------
// alide_pkg
// Shared types and constants for the array list insert/delete engine:
// list capacity, derived widths, request kinds, status codes, sequencer
// states and the store access bundle.
// ---------------------------------------------------------------------------
package alide_pkg;

  // list capacity and derived widths
  localparam int CAPACITY  = 64;
  localparam int WORD_W    = 32;
  localparam int KIND_W    = 4;
  localparam int POS_W     = 7;
  localparam int STAT_W    = 3;
  localparam int OUT_IDX_W = 7;
  localparam int OUT_CNT_W = 7;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT  = 4'd0,
    K_PUSH_BACK   = 4'd1,
    K_INSERT      = 4'd2,
    K_POP_FRONT   = 4'd3,
    K_POP_BACK    = 4'd4,
    K_ERASE       = 4'd5,
    K_MODIFY      = 4'd6,
    K_FIND        = 4'd7,
    K_REMOVE_FIRST = 4'd8,
    K_REMOVE_ALL  = 4'd9
  } kind_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_OPEN,
    S_CLOSE
  } state_t;

  // what the compaction walk drops
  typedef enum logic [1:0] {
    M_ERASE,
    M_FIND,
    M_RM_FIRST,
    M_RM_ALL
  } mode_t;

  // store access for a cycle: one read port, one write port
  typedef struct packed {
    logic  ren;
    idx_t  raddr;
    logic  wen;
    idx_t  waddr;
    word_t wdata;
  } store_req_t;

endpackage

// ===== design/alide_store.sv =====
// ---------------------------------------------------------------------------
// alide_store
// Entry store of the list: one write port and one registered read port
// (data the cycle after the read). Contents are undefined until written.
// ---------------------------------------------------------------------------
module alide_store (
  input  logic                clk,
  input  alide_pkg::store_req_t req,
  output alide_pkg::word_t    rd_data
);
  import alide_pkg::*;

  word_t entry_mem [CAPACITY];
  word_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wen) begin
      entry_mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.ren) begin
      rdata_r <= entry_mem[req.raddr];
    end
  end

  assign rd_data = rdata_r;

endmodule

// ===== design/array_list_insert_delete_engine.sv =====
// ---------------------------------------------------------------------------
// array_list_insert_delete_engine
// Ordered list of 32-bit words in a single-port-read/single-port-write store
// with an entry count. Inserts shift later entries up, deletes and
// remove-by-value compact the list, one entry per cycle.
//
//   channel  ports                                  handshake
//   -------  -------------------------------------  ----------------------
//   request  in_kind, in_pos, in_value              start high, busy low
//   result   out_status, out_found_index,           out_strobe, one cycle,
//            out_count, out_is_empty                no back-pressure
//
// Pop back, modify, rejected and unknown requests finish when taken.
// Insert/push, erase/pop front, find and both removes step through the
// entries moved or scanned, then drain the read pipeline and finish on
// the store's single ports.
// The result strobe comes the cycle after the request completes; a new
// request may be taken in that same cycle.
// Reset (rst_n low, synchronous) empties the list; no clearing pass.
// ---------------------------------------------------------------------------
module array_list_insert_delete_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [alide_pkg::KIND_W-1:0]      in_kind,
  input  logic [alide_pkg::POS_W-1:0]       in_pos,
  input  logic signed [alide_pkg::WORD_W-1:0] in_value,
  output logic                              out_strobe,
  output logic [alide_pkg::STAT_W-1:0]      out_status,
  output logic signed [alide_pkg::OUT_IDX_W-1:0] out_found_index,
  output logic [alide_pkg::OUT_CNT_W-1:0]   out_count,
  output logic                              out_is_empty
);
  import alide_pkg::*;

  // control state
  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  logic   vld_r, vld_nxt;
  logic   out_strobe_r, out_strobe_nxt;

  // request payload and walk pointers
  mode_t  mode_r, mode_nxt;
  idx_t   at_r, at_nxt;
  word_t  word_r, word_nxt;
  cnt_t   ptr_r, ptr_nxt;
  cnt_t   wr_r, wr_nxt;
  idx_t   tag_r, tag_nxt;
  logic   hit_r, hit_nxt;
  idx_t   hit_idx_r, hit_idx_nxt;

  // result registers
  status_t               out_status_r, out_status_nxt;
  logic [OUT_IDX_W-1:0]  out_found_r, out_found_nxt;
  logic [OUT_CNT_W-1:0]  out_count_r, out_count_nxt;
  logic                  out_empty_r, out_empty_nxt;

  // completion bundle
  logic                  fin;
  status_t               fin_status;
  logic [OUT_IDX_W-1:0]  fin_found;
  cnt_t                  fin_count;

  store_req_t mreq;
  word_t      rdata;
  logic [CMP_W-1:0] pos_c, cnt_c;
  logic       full, match, drop;

  alide_store u_store (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rdata)
  );

  assign pos_c = CMP_W'(in_pos);
  assign cnt_c = CMP_W'(count_r);
  assign full  = (count_r >= CNT_W'(CAPACITY));
  assign match = (rdata == word_r);

  // drop decision for the entry coming back from the store
  always_comb begin
    case (mode_r)
      M_ERASE:    drop = (tag_r == at_r);
      M_RM_FIRST: drop = match && !hit_r;
      M_RM_ALL:   drop = match;
      default:    drop = 1'b0;
    endcase
  end

  // next state, store access and results
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    vld_nxt     = vld_r;
    mode_nxt    = mode_r;
    at_nxt      = at_r;
    word_nxt    = word_r;
    ptr_nxt     = ptr_r;
    wr_nxt      = wr_r;
    tag_nxt     = tag_r;
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_strobe_nxt = 1'b0;
    mreq       = '0;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_found  = '1;
    fin_count  = count_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          word_nxt = in_value;
          hit_nxt  = 1'b0;
          vld_nxt  = 1'b0;
          ptr_nxt  = '0;
          wr_nxt   = '0;
          case (kind_t'(in_kind))
            K_PUSH_FRONT, K_PUSH_BACK, K_INSERT: begin
              if (full) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end else if (kind_t'(in_kind) == K_INSERT && pos_c > cnt_c) begin
                fin        = 1'b1;
                fin_status = STAT_BADPOS;
              end else begin
                case (kind_t'(in_kind))
                  K_PUSH_FRONT: at_nxt = '0;
                  K_PUSH_BACK:  at_nxt = IDX_W'(count_r);
                  default:      at_nxt = IDX_W'(in_pos);
                endcase
                ptr_nxt   = count_r;
                state_nxt = S_OPEN;
              end
            end
            K_POP_BACK: begin
              fin = 1'b1;
              if (count_r == '0) begin
                fin_status = STAT_EMPTY;
              end else begin
                fin_count = count_r - CNT_W'(1);
              end
            end
            K_POP_FRONT: begin
              if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = STAT_EMPTY;
              end else begin
                mode_nxt  = M_ERASE;
                at_nxt    = '0;
                state_nxt = S_CLOSE;
              end
            end
            K_ERASE: begin
              if (pos_c >= cnt_c) begin
                fin        = 1'b1;
                fin_status = STAT_BADPOS;
              end else begin
                mode_nxt  = M_ERASE;
                at_nxt    = IDX_W'(in_pos);
                ptr_nxt   = CNT_W'(in_pos);
                wr_nxt    = CNT_W'(in_pos);
                state_nxt = S_CLOSE;
              end
            end
            K_MODIFY: begin
              fin = 1'b1;
              if (pos_c >= cnt_c) begin
                fin_status = STAT_BADPOS;
              end else begin
                mreq.wen   = 1'b1;
                mreq.waddr = IDX_W'(in_pos);
                mreq.wdata = in_value;
              end
            end
            K_FIND: begin
              mode_nxt  = M_FIND;
              state_nxt = S_CLOSE;
            end
            K_REMOVE_FIRST: begin
              mode_nxt  = M_RM_FIRST;
              state_nxt = S_CLOSE;
            end
            K_REMOVE_ALL: begin
              mode_nxt  = M_RM_ALL;
              state_nxt = S_CLOSE;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // shift entries up from the tail down to the gap, then fill the gap
      S_OPEN: begin
        if (vld_r) begin
          mreq.wen   = 1'b1;
          mreq.waddr = tag_r;
          mreq.wdata = rdata;
        end
        if (ptr_r > CNT_W'(at_r)) begin
          mreq.ren   = 1'b1;
          mreq.raddr = IDX_W'(ptr_r - CNT_W'(1));
          tag_nxt    = IDX_W'(ptr_r);
          ptr_nxt    = ptr_r - CNT_W'(1);
          vld_nxt    = 1'b1;
        end else begin
          vld_nxt = 1'b0;
          if (!vld_r) begin
            mreq.wen   = 1'b1;
            mreq.waddr = at_r;
            mreq.wdata = word_r;
            fin        = 1'b1;
            fin_count  = count_r + CNT_W'(1);
            state_nxt  = S_IDLE;
          end
        end
      end

      // walk the list, noting the first hit and, but for find, compacting past dropped entries
      S_CLOSE: begin
        if (vld_r) begin
          if (match && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = tag_r;
          end
          if (!drop && mode_r != M_FIND) begin
            mreq.wen   = 1'b1;
            mreq.waddr = IDX_W'(wr_r);
            mreq.wdata = rdata;
            wr_nxt     = wr_r + CNT_W'(1);
          end
        end
        if (ptr_r < count_r) begin
          mreq.ren   = 1'b1;
          mreq.raddr = IDX_W'(ptr_r);
          tag_nxt    = IDX_W'(ptr_r);
          ptr_nxt    = ptr_r + CNT_W'(1);
          vld_nxt    = 1'b1;
        end else begin
          vld_nxt = 1'b0;
          if (!vld_r) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
            if (mode_r == M_FIND) begin
              if (hit_r) begin
                fin_found = OUT_IDX_W'(hit_idx_r);
              end else begin
                fin_status = STAT_NOTFOUND;
              end
            end else begin
              fin_count = wr_r;
              if ((mode_r == M_RM_FIRST || mode_r == M_RM_ALL) && !hit_r) begin
                fin_status = STAT_NOTFOUND;
              end
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
        vld_nxt   = 1'b0;
      end
    endcase

    // load the result registers on completion
    if (fin) begin
      count_nxt      = fin_count;
      out_strobe_nxt = 1'b1;
      out_status_nxt = fin_status;
      out_found_nxt  = fin_found;
      out_count_nxt  = OUT_CNT_W'(fin_count);
      out_empty_nxt  = (fin_count == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      vld_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      vld_r        <= vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    at_r         <= at_nxt;
    word_r       <= word_nxt;
    ptr_r        <= ptr_nxt;
    wr_r         <= wr_nxt;
    tag_r        <= tag_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_count       = out_count_r;
  assign out_is_empty    = out_empty_r;

endmodule

// ===== design/alide_chk.sv =====
// ---------------------------------------------------------------------------
// alide_chk
// Port-level checks for the array list insert/delete engine, bound to the
// top level.
// ---------------------------------------------------------------------------
module alide_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [alide_pkg::KIND_W-1:0]      in_kind,
  input logic [alide_pkg::POS_W-1:0]       in_pos,
  input logic signed [alide_pkg::WORD_W-1:0] in_value,
  input logic                              out_strobe,
  input logic [alide_pkg::STAT_W-1:0]      out_status,
  input logic signed [alide_pkg::OUT_IDX_W-1:0] out_found_index,
  input logic [alide_pkg::OUT_CNT_W-1:0]   out_count,
  input logic                              out_is_empty
);
  import alide_pkg::*;

  // a taken request either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("request taken but neither busy nor result");

  // empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_is_empty == (out_count == '0))
    else $error("empty flag disagrees with count");

  // count never exceeds the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_count <= OUT_CNT_W'(CAPACITY))
    else $error("count above capacity");

  // a failed request never reports a found index
  a_found_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != STAT_OK |-> out_found_index == '1)
    else $error("found index on failed request");

  // a found index lies inside the list
  a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_found_index != '1 |->
      $unsigned(out_found_index) < out_count)
    else $error("found index outside list");

endmodule

bind array_list_insert_delete_engine alide_chk u_alide_chk (.*);

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the array list insert/delete engine. A short
// table of directed requests covers empty-list errors, bad positions,
// extreme words, unknown kinds and adjacent duplicates. Random requests
// follow, in mixes that grow the list to full, drain it and fill it with
// duplicates. Every result is checked against a list model kept in the
// bench, or against the expected result typed into a directed row.
// ---------------------------------------------------------------------------
module testbench;
  import alide_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 8;
  localparam int N_DIRECTED   = 24;
  localparam int N_RANDOM     = 526;
  localparam int N_TOTAL      = N_DIRECTED + N_RANDOM;
  localparam int DRAIN_EVERY  = 137;
  localparam int MIX_LEN      = 80;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 2 * CAPACITY + 20;

  // kinds the block ignores
  localparam logic [KIND_W-1:0] K_UNUSED_LO = 4'd10;
  localparam logic [KIND_W-1:0] K_UNUSED_HI = 4'd15;

  localparam logic [OUT_IDX_W-1:0] NO_INDEX = '1;
  localparam logic [POS_W-1:0]     POS_MAX  = '1;

  localparam word_t W_ZERO = 32'h0000_0000;
  localparam word_t W_ONES = 32'hFFFF_FFFF;
  localparam word_t W_MIN  = 32'h8000_0000;
  localparam word_t W_MAX  = 32'h7FFF_FFFF;
  localparam word_t W_ALT  = 32'h5555_5555;
  localparam word_t W_ONE  = 32'h0000_0001;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [OUT_IDX_W-1:0] found_index;
    logic [OUT_CNT_W-1:0] count;
    logic                 is_empty;
  } list_result_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     pos;
    word_t                value;
    logic                 typed;
    logic [STAT_W-1:0]    w_status;
    logic [OUT_IDX_W-1:0] w_found;
    logic [OUT_CNT_W-1:0] w_count;
    logic                 w_empty;
  } list_request_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [POS_W-1:0] in_pos = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic out_strobe;
  logic [STAT_W-1:0] out_status;
  logic signed [OUT_IDX_W-1:0] out_found_index;
  logic [OUT_CNT_W-1:0] out_count;
  logic out_is_empty;

  // list model state
  word_t       list_words [CAPACITY];
  int unsigned list_len = 0;

  list_result_t  expected_results [$];
  list_request_t cur;
  list_result_t  want;
  list_result_t  got;
  int  sent_count  = 0;
  int  fail_count  = 0;
  int  idle_cycles = 0;
  int  burst_left  = 0;
  int  gap_left    = 0;
  bit  hold_drain  = 1'b0;
  bit  timed_out   = 1'b0;
  bit  progress;
  bit  drain_now;

  array_list_insert_delete_engine u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_pos          (in_pos),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty)
  );

  always #(CLK_HALF) clk = ~clk;

  // shift entries at and above the slot up by one, then write the slot
  function automatic void open_slot(input int unsigned at, input word_t word);
    int unsigned i;
    for (i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
    list_words[at] = word;
    list_len++;
  endfunction

  // shift entries above the slot down by one
  function automatic void close_slot(input int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
  endfunction

  // index of the first match, list_len when none
  function automatic int unsigned first_index(input word_t word);
    int unsigned i;
    for (i = 0; i < list_len; i++) if (list_words[i] == word) return i;
    return list_len;
  endfunction

  // apply one request to the list model and give its result
  function automatic list_result_t list_apply(input logic [KIND_W-1:0] kind,
                                              input logic [POS_W-1:0] pos,
                                              input word_t word);
    list_result_t r;
    int unsigned at, kept, rd;
    bit full;
    r.status = STAT_OK;
    r.found_index = NO_INDEX;
    full = (list_len >= CAPACITY);
    case (kind)
      K_PUSH_FRONT: if (full) r.status = STAT_FULL; else open_slot(0, word);
      K_PUSH_BACK:  if (full) r.status = STAT_FULL; else open_slot(list_len, word);
      K_INSERT: begin
        if (full) r.status = STAT_FULL;
        else if (pos > list_len) r.status = STAT_BADPOS;
        else open_slot(pos, word);
      end
      K_POP_FRONT: if (list_len == 0) r.status = STAT_EMPTY; else close_slot(0);
      K_POP_BACK:  if (list_len == 0) r.status = STAT_EMPTY; else list_len--;
      K_ERASE:  if (pos >= list_len) r.status = STAT_BADPOS; else close_slot(pos);
      K_MODIFY: if (pos >= list_len) r.status = STAT_BADPOS; else list_words[pos] = word;
      K_FIND: begin
        at = first_index(word);
        if (at >= list_len) r.status = STAT_NOTFOUND;
        else r.found_index = OUT_IDX_W'(at);
      end
      K_REMOVE_FIRST: begin
        at = first_index(word);
        if (at >= list_len) r.status = STAT_NOTFOUND; else close_slot(at);
      end
      K_REMOVE_ALL: begin
        // compact in place, keeping every non-matching word in order
        kept = 0;
        for (rd = 0; rd < list_len; rd++) begin
          if (list_words[rd] != word) begin
            list_words[kept] = list_words[rd];
            kept++;
          end
        end
        if (kept == list_len) r.status = STAT_NOTFOUND;
        list_len = kept;
      end
      default: ;
    endcase
    r.count = OUT_CNT_W'(list_len);
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  // directed stimulus, expected result typed where it is obvious
  function automatic list_request_t directed_row(input int row);
    list_request_t r;
    case (row)
      0:  r = '{K_POP_FRONT,    7'd0,  W_ZERO, 1'b1, STAT_EMPTY,    NO_INDEX, 7'd0, 1'b1};
      1:  r = '{K_POP_BACK,     7'd0,  W_ZERO, 1'b1, STAT_EMPTY,    NO_INDEX, 7'd0, 1'b1};
      2:  r = '{K_ERASE,        7'd0,  W_ZERO, 1'b1, STAT_BADPOS,   NO_INDEX, 7'd0, 1'b1};
      3:  r = '{K_MODIFY,       7'd0,  W_ONES, 1'b1, STAT_BADPOS,   NO_INDEX, 7'd0, 1'b1};
      4:  r = '{K_FIND,         7'd0,  W_ZERO, 1'b1, STAT_NOTFOUND, NO_INDEX, 7'd0, 1'b1};
      5:  r = '{K_REMOVE_FIRST, 7'd0,  W_ZERO, 1'b1, STAT_NOTFOUND, NO_INDEX, 7'd0, 1'b1};
      6:  r = '{K_REMOVE_ALL,   7'd0,  W_ZERO, 1'b1, STAT_NOTFOUND, NO_INDEX, 7'd0, 1'b1};
      7:  r = '{K_INSERT,       7'd1,  W_ONES, 1'b1, STAT_BADPOS,   NO_INDEX, 7'd0, 1'b1};
      8:  r = '{K_INSERT,       7'd0,  W_MIN,  1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      9:  r = '{K_PUSH_BACK,    7'd0,  W_MAX,  1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      10: r = '{K_PUSH_FRONT,   7'd0,  W_ONES, 1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      11: r = '{K_FIND,         7'd0,  W_MAX,  1'b1, STAT_OK,       7'd2,     7'd3, 1'b0};
      12: r = '{K_FIND,         7'd0,  W_ONES, 1'b1, STAT_OK,       7'd0,     7'd3, 1'b0};
      13: r = '{K_INSERT,       7'd3,  W_ZERO, 1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      14: r = '{K_INSERT,       POS_MAX, W_ALT, 1'b1, STAT_BADPOS,  NO_INDEX, 7'd4, 1'b0};
      15: r = '{K_MODIFY,       7'd1,  W_ONES, 1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      16: r = '{K_ERASE,        7'd4,  W_ZERO, 1'b1, STAT_BADPOS,   NO_INDEX, 7'd4, 1'b0};
      // adjacent duplicates at the head
      17: r = '{K_REMOVE_ALL,   7'd0,  W_ONES, 1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      18: r = '{K_UNUSED_LO,    7'd0,  W_ZERO, 1'b1, STAT_OK,       NO_INDEX, 7'd2, 1'b0};
      19: r = '{K_UNUSED_HI,    POS_MAX, W_ONES, 1'b1, STAT_OK,     NO_INDEX, 7'd2, 1'b0};
      20: r = '{K_PUSH_BACK,    7'd0,  W_ALT,  1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      21: r = '{K_REMOVE_FIRST, 7'd0,  W_ZERO, 1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      22: r = '{K_ERASE,        7'd0,  W_ZERO, 1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
      default: r = '{K_POP_BACK, 7'd0, W_ZERO, 1'b0, STAT_OK,       NO_INDEX, 7'd0, 1'b0};
    endcase
    return r;
  endfunction

  function automatic word_t pool_word(input int unsigned idx);
    case (idx)
      0: return W_ZERO;
      1: return W_ONES;
      2: return W_MIN;
      3: return W_MAX;
      4: return W_ALT;
      default: return W_ONE;
    endcase
  endfunction

  // words already in the list, a few hot values, or anything
  function automatic word_t pick_word(input bit dup_mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (list_len != 0 && roll < 40) return list_words[$urandom_range(0, list_len - 1)];
    if (dup_mix || roll < 70) return pool_word($urandom_range(0, dup_mix ? 2 : 5));
    return $urandom;
  endfunction

  // mostly legal positions, then the edges, then anything
  function automatic logic [POS_W-1:0] pick_pos(input bit for_insert);
    int unsigned roll, top;
    roll = $urandom_range(0, 99);
    top = for_insert ? list_len : ((list_len == 0) ? 0 : list_len - 1);
    if (roll < 70) return POS_W'($urandom_range(0, top));
    if (roll < 85) return POS_W'(list_len + $urandom_range(0, 1));
    return POS_W'($urandom_range(0, POS_MAX));
  endfunction

  // kind mix: 0 balanced, 1 grow to full, 2 drain, 3 duplicates
  function automatic logic [KIND_W-1:0] pick_kind(input int mix);
    int unsigned roll;
    logic [KIND_W-1:0] any_kind;
    roll = $urandom_range(0, 99);
    any_kind = KIND_W'($urandom_range(K_PUSH_FRONT, K_REMOVE_ALL));
    if (roll < 3) return KIND_W'(K_UNUSED_LO + $urandom_range(0, K_UNUSED_HI - K_UNUSED_LO));
    case (mix)
      1: begin
        if (roll < 33) return K_PUSH_BACK;
        if (roll < 55) return K_PUSH_FRONT;
        if (roll < 88) return K_INSERT;
      end
      2: begin
        if (roll < 20) return K_POP_FRONT;
        if (roll < 40) return K_POP_BACK;
        if (roll < 60) return K_ERASE;
        if (roll < 75) return K_REMOVE_FIRST;
        if (roll < 85) return K_REMOVE_ALL;
      end
      3: begin
        if (roll < 25) return K_PUSH_BACK;
        if (roll < 45) return K_INSERT;
        if (roll < 60) return K_FIND;
        if (roll < 75) return K_REMOVE_FIRST;
        if (roll < 88) return K_REMOVE_ALL;
      end
      default: ;
    endcase
    return any_kind;
  endfunction

  function automatic list_request_t next_request(input int n);
    list_request_t r;
    int mix;
    if (n < N_DIRECTED) return directed_row(n);
    mix = ((n - N_DIRECTED) / MIX_LEN) % 4;
    r = '0;
    r.kind = pick_kind(mix);
    if (r.kind == K_INSERT) r.pos = pick_pos(1'b1);
    else if (r.kind == K_ERASE || r.kind == K_MODIFY) r.pos = pick_pos(1'b0);
    else r.pos = POS_W'($urandom_range(0, POS_MAX));
    r.value = pick_word(mix == 3);
    return r;
  endfunction

  // result check, request issue and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      progress = 1'b0;

      // check a result against the oldest expectation
      if (out_strobe) begin
        progress = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d count %0d",
                 out_status, out_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d",
                   $signed(want.found_index), out_found_index);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count);
            fail_count++;
          end
          if (out_is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_is_empty);
            fail_count++;
          end
        end
      end

      // request accepted: predict it, then carry on or pause
      if (start && !busy) begin
        progress = 1'b1;
        got = list_apply(cur.kind, cur.pos, cur.value);
        if (cur.typed) expected_results.push_back({cur.w_status, cur.w_found,
                                                   cur.w_count, cur.w_empty});
        else expected_results.push_back(got);
        sent_count++;
        if (burst_left > 0) burst_left--;
        drain_now = (sent_count == N_DIRECTED) ||
                    (sent_count > N_DIRECTED && (sent_count - N_DIRECTED) % DRAIN_EVERY == 0);
        if (sent_count == N_TOTAL) begin
          start <= 1'b0;
        end else if (drain_now) begin
          start <= 1'b0;
          hold_drain = 1'b1;
          gap_left = 0;
        end else if (burst_left == 0) begin
          start <= 1'b0;
          gap_left = $urandom_range(0, 10);
        end else begin
          cur = next_request(sent_count);
          in_kind <= cur.kind;
          in_pos <= cur.pos;
          in_value <= cur.value;
        end
      end else if (!start && sent_count < N_TOTAL) begin
        // idle sender: wait out a drain or a gap, then start a burst
        if (hold_drain) begin
          if (expected_results.size() == 0) hold_drain = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          cur = next_request(sent_count);
          in_kind <= cur.kind;
          in_pos <= cur.pos;
          in_value <= cur.value;
          start <= 1'b1;
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 8);
        end
      end

      // watchdog on cycles with no request and no result
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end
  end

  // reset, then wait for the stimulus to drain
  initial begin
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (!timed_out && !(sent_count == N_TOTAL && expected_results.size() == 0))
      @(posedge clk);
    if (timed_out) begin
      $display("tb: failure");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (fail_count == 0 && expected_results.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule
